// ----- sv/hvs_pkg.sv -----
// Shared types, constants and divider step functions for the hue rotation block.
package hvs_pkg;

    localparam int CHAN_W    = 8;
    localparam int HUE_FRAC  = 6;
    localparam int OUT_DEPTH = 32;
    localparam int MID_DEPTH = 4;

    localparam logic [7:0]  CHAN_MAX  = 8'd255;
    localparam logic [11:0] SECT_SPAN = 12'd3840;      // 60 degrees, 6 fraction bits
    localparam logic [15:0] HUE_FULL  = 16'd23040;     // 360 degrees
    localparam logic [15:0] HUE_120   = 16'd7680;
    localparam logic [15:0] HUE_240   = 16'd15360;
    localparam logic [19:0] DEN       = 20'd979200;    // CHAN_MAX * SECT_SPAN
    localparam logic [8:0]  DEG_360   = 9'd360;

    // reciprocals for exact floor division by constants
    localparam logic [16:0] RECIP_255  = 17'd65794;    // ceil(2^24 / 255), x < 66052
    localparam logic [20:0] RECIP_3825 = 21'd1122868;  // ceil(2^32 / 3825), DEN = 3825 << 8

    localparam logic [1:0] SECT_R = 2'd0;
    localparam logic [1:0] SECT_G = 2'd1;
    localparam logic [1:0] SECT_B = 2'd2;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [7:0] alpha_in;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] alpha_out;
    } t_pix_out;

    // classified pixel handed from front to back
    typedef struct packed {
        logic       grey;
        logic       neg;
        logic [1:0] sect;
        logic [7:0] mx;
        logic [7:0] delta;
        logic [7:0] mag;
        logic [7:0] alpha;
    } t_cls;

    typedef struct packed {
        logic [5:0] cred;
        logic [5:0] fill;
    } t_bk_stat;

    // restoring division steps: z = {remainder, numerator bits / quotient bits}
    function automatic logic [16:0] div_step8(input logic [16:0] z, input logic [7:0] d);
        logic [16:0] t;
        t = {z[15:0], 1'b0};
        if (t[16:8] >= {1'b0, d}) begin
            t[16:8] = t[16:8] - {1'b0, d};
            t[0]    = 1'b1;
        end
        return t;
    endfunction

    function automatic logic [21:0] div_step12(input logic [21:0] z, input logic [8:0] d);
        logic [21:0] t;
        t = {z[20:0], 1'b0};
        if (t[21:12] >= {1'b0, d}) begin
            t[21:12] = t[21:12] - {1'b0, d};
            t[0]     = 1'b1;
        end
        return t;
    endfunction

endpackage

// ----- sv/pixel_hue_rotation.sv -----
// Top level of the RGBA hue rotation block.
//
// Input side is a queue write port: a pixel is taken on a clock edge with
// push high and full low. Result side is a queue read port: while empty is
// low the oldest rotated pixel sits on o_pix, and pop takes it.
// The hue offset register (degrees, reset 0) is written through the cfg
// channel; it is always ready. Write it only while no pixel is in flight.
// Throughput is one pixel per clock while full is low. An accepted pixel
// passes the front register, the 4-word queue, 13 divider stages (8- and
// 12-step restoring dividers side by side), hue, offset/sector, product
// and numerator stages, and a reciprocal-multiply step that writes the
// 32-word result queue.
// Pipeline issue is credit based on the result queue, so a stalled reader
// holds words in that queue, then in the front queue, then raises full.
// Reset empties all queues; empty goes high and full low.
module pixel_hue_rotation (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  hvs_pkg::t_pix_in  i_pix,
    output logic              empty,
    input  logic              pop,
    output hvs_pkg::t_pix_out o_pix,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [8:0]        i_cfg_data
);
    import hvs_pkg::*;

    logic     [8:0] r_hue_offset;
    logic     f_valid, q_full, q_empty, q_pop;
    t_cls     f_cls, q_data;
    t_bk_stat bk_stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_offset <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_hue_offset <= i_cfg_data;
        end
    end

    hvs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pix    (i_pix),
        .i_q_full (q_full),
        .o_full   (full),
        .o_valid  (f_valid),
        .o_cls    (f_cls)
    );

    hvs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  (f_cls),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_data)
    );

    hvs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_q_data     (q_data),
        .o_q_pop      (q_pop),
        .i_hue_offset (r_hue_offset),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_pix        (o_pix),
        .o_stat       (bk_stat)
    );

`ifndef SYNTHESIS
    a_fill_le_cred: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bk_stat.fill <= bk_stat.cred)
        else $error("result queue holds more words than credits");

    a_cred_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bk_stat.cred <= 6'(OUT_DEPTH))
        else $error("credit count above result queue depth");

    a_empty_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        empty == (bk_stat.fill == 6'd0))
        else $error("empty flag disagrees with result queue fill");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("block not idle after reset");
`endif

endmodule

// ----- sv/hvs_front.sv -----
// Front end: takes pixels, finds max/min, hue sector and grey case.
module hvs_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hvs_pkg::t_pix_in i_pix,
    input  logic          i_q_full,
    output logic          o_full,
    output logic          o_valid,
    output hvs_pkg::t_cls o_cls
);
    import hvs_pkg::*;

    logic       r_valid;
    t_cls       r_cls;
    t_cls       n_cls;
    logic       advance;
    logic [7:0] mx, mn, hi, lo;

    assign advance = !r_valid || !i_q_full;
    assign o_full  = !advance;
    assign o_valid = r_valid;
    assign o_cls   = r_cls;

    always_comb begin
        mx = i_pix.red_in;
        mn = i_pix.red_in;
        if (i_pix.green_in > mx) mx = i_pix.green_in;
        if (i_pix.blue_in > mx)  mx = i_pix.blue_in;
        if (i_pix.green_in < mn) mn = i_pix.green_in;
        if (i_pix.blue_in < mn)  mn = i_pix.blue_in;
        // ties for max: red, then green, then blue
        if (i_pix.red_in == mx) begin
            hi = i_pix.green_in; lo = i_pix.blue_in; n_cls.sect = SECT_R;
        end else if (i_pix.green_in == mx) begin
            hi = i_pix.blue_in; lo = i_pix.red_in; n_cls.sect = SECT_G;
        end else begin
            hi = i_pix.red_in; lo = i_pix.green_in; n_cls.sect = SECT_B;
        end
        n_cls.mx    = mx;
        n_cls.delta = mx - mn;
        n_cls.grey  = (mx == mn);
        n_cls.neg   = (hi < lo);
        n_cls.mag   = (hi >= lo) ? hi - lo : lo - hi;
        n_cls.alpha = i_pix.alpha_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= i_push;
        end
        if (advance) begin
            r_cls <= n_cls;
        end
    end

endmodule

// ----- sv/hvs_queue.sv -----
// Short queue of classified pixels between front and back.
module hvs_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hvs_pkg::t_cls i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output hvs_pkg::t_cls o_data
);
    import hvs_pkg::*;

    t_cls       r_mem [0:MID_DEPTH-1];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       wr, rd;

    assign o_full  = (r_cnt == 3'(MID_DEPTH));
    assign o_empty = (r_cnt == 3'd0);
    assign o_data  = r_mem[r_rp];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= r_wp + 2'd1;
            if (rd) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(wr) - 3'(rd);
        end
        if (wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ----- sv/hvs_back.sv -----
// Back end: pipelined dividers, hue offset, p/q/t rebuild and result queue.
module hvs_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  hvs_pkg::t_cls     i_q_data,
    output logic              o_q_pop,
    input  logic [8:0]        i_hue_offset,
    input  logic              i_pop,
    output logic              o_empty,
    output hvs_pkg::t_pix_out o_pix,
    output hvs_pkg::t_bk_stat o_stat
);
    import hvs_pkg::*;

    localparam int NA = 12;

    typedef struct packed {
        logic        grey;
        logic        neg;
        logic [1:0]  sect;
        logic [7:0]  mx;
        logic [7:0]  alpha;
        logic [7:0]  ds;
        logic [8:0]  dq;
        logic [16:0] zs;
        logic [21:0] zq;
    } t_div;

    typedef struct packed {
        logic       grey;
        logic [7:0] mx;
        logic [7:0] alpha;
        logic [7:0] s;
        logic [8:0] ip;
        logic [5:0] fr;
    } t_h1;

    typedef struct packed {
        logic        grey;
        logic [7:0]  mx;
        logic [7:0]  alpha;
        logic [7:0]  s;
        logic [2:0]  sec;
        logic [11:0] pos;
    } t_h2;

    typedef struct packed {
        logic        grey;
        logic [7:0]  mx;
        logic [7:0]  alpha;
        logic [7:0]  s;
        logic [2:0]  sec;
        logic [19:0] sp;
        logic [19:0] sq;
    } t_m1;

    typedef struct packed {
        logic        grey;
        logic [7:0]  mx;
        logic [7:0]  alpha;
        logic [2:0]  sec;
        logic [15:0] pnum;
        logic [27:0] qnum;
        logic [27:0] tnum;
    } t_cd;

    t_div r_a [0:NA];
    t_div n_a [0:NA];
    logic [NA:0] r_av;
    t_h1  r_h1, n_h1;
    t_h2  r_h2, n_h2;
    t_m1  r_m1, n_m1;
    logic r_h1v, r_h2v, r_m1v;
    t_cd  r_c, n_c;
    logic r_cv;

    t_pix_out    r_mem [0:OUT_DEPTH-1];
    t_pix_out    res;
    logic [4:0]  r_wp, r_rp;
    logic [5:0]  r_fill, r_cred;
    logic        issue, rd;

    logic [15:0] h;
    logic [15:0] qv;
    logic [15:0] base;
    logic [9:0]  sum;
    logic [8:0]  ip;
    logic [8:0]  sec60;
    logic [2:0]  sec;
    logic [32:0] pprod;
    logic [40:0] qprod, tprod;
    logic [7:0]  p_val, q_val, t_val;

    // credit covers every word in flight plus every word queued
    assign issue   = !i_q_empty && (r_cred < 6'(OUT_DEPTH));
    assign o_q_pop = issue;
    assign rd      = i_pop && (r_fill != 6'd0);
    assign o_empty = (r_fill == 6'd0);
    assign o_pix   = r_mem[r_rp];
    assign o_stat  = '{cred: r_cred, fill: r_fill};

    always_comb begin
        n_a[0].grey  = i_q_data.grey;
        n_a[0].neg   = i_q_data.neg;
        n_a[0].sect  = i_q_data.sect;
        n_a[0].mx    = i_q_data.mx;
        n_a[0].alpha = i_q_data.alpha;
        n_a[0].ds    = i_q_data.mx;
        n_a[0].dq    = {i_q_data.delta, 1'b0};
        // s = round(delta*255/mx), hue term = round(3840*mag/delta)
        n_a[0].zs    = {1'b0, 16'(i_q_data.delta) * 16'(CHAN_MAX) + 16'(i_q_data.mx >> 1)};
        n_a[0].zq    = {1'b0, 21'(i_q_data.mag) * 21'({SECT_SPAN, 1'b0})
                              + 21'(i_q_data.delta)};
        for (int k = 0; k < NA; k++) begin
            n_a[k+1]    = r_a[k];
            n_a[k+1].zq = div_step12(r_a[k].zq, r_a[k].dq);
            if (k < 8) begin
                n_a[k+1].zs = div_step8(r_a[k].zs, r_a[k].ds);
            end
        end
    end

    always_comb begin
        qv = 16'(r_a[NA].zq[11:0]);
        case (r_a[NA].sect)
            SECT_G:  base = HUE_120;
            SECT_B:  base = HUE_240;
            default: base = 16'd0;
        endcase
        h = r_a[NA].neg ? base + HUE_FULL - qv : base + qv;
        if (h >= HUE_FULL) h = h - HUE_FULL;
        n_h1.grey  = r_a[NA].grey;
        n_h1.mx    = r_a[NA].mx;
        n_h1.alpha = r_a[NA].alpha;
        n_h1.s     = r_a[NA].zs[7:0];
        n_h1.ip    = h[14:6];
        n_h1.fr    = h[5:0];
    end

    always_comb begin
        sum = 10'(r_h1.ip) + 10'(i_hue_offset);
        if (sum >= 10'd720)      ip = 9'(sum - 10'd720);
        else if (sum >= 10'd360) ip = 9'(sum - 10'd360);
        else                     ip = 9'(sum);
        if (ip >= 9'd300)      begin sec = 3'd5; sec60 = 9'd300; end
        else if (ip >= 9'd240) begin sec = 3'd4; sec60 = 9'd240; end
        else if (ip >= 9'd180) begin sec = 3'd3; sec60 = 9'd180; end
        else if (ip >= 9'd120) begin sec = 3'd2; sec60 = 9'd120; end
        else if (ip >= 9'd60)  begin sec = 3'd1; sec60 = 9'd60;  end
        else                   begin sec = 3'd0; sec60 = 9'd0;   end
        n_h2.grey  = r_h1.grey;
        n_h2.mx    = r_h1.mx;
        n_h2.alpha = r_h1.alpha;
        n_h2.s     = r_h1.s;
        n_h2.sec   = sec;
        n_h2.pos   = {6'(ip - sec60), r_h1.fr};
    end

    always_comb begin
        n_m1.grey  = r_h2.grey;
        n_m1.mx    = r_h2.mx;
        n_m1.alpha = r_h2.alpha;
        n_m1.s     = r_h2.s;
        n_m1.sec   = r_h2.sec;
        n_m1.sp    = 20'(r_h2.s) * 20'(r_h2.pos);
        n_m1.sq    = 20'(r_h2.s) * 20'(SECT_SPAN - r_h2.pos);
    end

    always_comb begin
        n_c.grey  = r_m1.grey;
        n_c.mx    = r_m1.mx;
        n_c.alpha = r_m1.alpha;
        n_c.sec   = r_m1.sec;
        n_c.pnum  = 16'(r_m1.mx) * 16'(CHAN_MAX - r_m1.s) + 16'd127;
        n_c.qnum  = 28'(r_m1.mx) * 28'(DEN - r_m1.sp) + 28'(DEN >> 1);
        n_c.tnum  = 28'(r_m1.mx) * 28'(DEN - r_m1.sq) + 28'(DEN >> 1);
    end

    // floor divisions by 255 and by DEN as reciprocal multiplies;
    // DEN is 3825 << 8, so drop the low 8 numerator bits first
    always_comb begin
        pprod = 33'(r_c.pnum) * 33'(RECIP_255);
        qprod = 41'(r_c.qnum[27:8]) * 41'(RECIP_3825);
        tprod = 41'(r_c.tnum[27:8]) * 41'(RECIP_3825);
        p_val = pprod[31:24];
        q_val = qprod[39:32];
        t_val = tprod[39:32];
    end

    always_comb begin
        res.alpha_out = r_c.alpha;
        case (r_c.sec)
            3'd0: begin
                res.red_out = r_c.mx;   res.green_out = t_val;
                res.blue_out = p_val;
            end
            3'd1: begin
                res.red_out = q_val;    res.green_out = r_c.mx;
                res.blue_out = p_val;
            end
            3'd2: begin
                res.red_out = p_val;    res.green_out = r_c.mx;
                res.blue_out = t_val;
            end
            3'd3: begin
                res.red_out = p_val;    res.green_out = q_val;
                res.blue_out = r_c.mx;
            end
            3'd4: begin
                res.red_out = t_val;    res.green_out = p_val;
                res.blue_out = r_c.mx;
            end
            default: begin
                res.red_out = r_c.mx;   res.green_out = p_val;
                res.blue_out = q_val;
            end
        endcase
        if (r_c.grey) begin
            res.red_out   = r_c.mx;
            res.green_out = r_c.mx;
            res.blue_out  = r_c.mx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av   <= '0;
            r_h1v  <= 1'b0;
            r_h2v  <= 1'b0;
            r_m1v  <= 1'b0;
            r_cv   <= 1'b0;
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
            r_cred <= '0;
        end else begin
            r_av   <= {r_av[NA-1:0], issue};
            r_h1v  <= r_av[NA];
            r_h2v  <= r_h1v;
            r_m1v  <= r_h2v;
            r_cv   <= r_m1v;
            if (r_cv) r_wp <= r_wp + 5'd1;
            if (rd)   r_rp <= r_rp + 5'd1;
            r_fill <= r_fill + 6'(r_cv) - 6'(rd);
            r_cred <= r_cred + 6'(issue) - 6'(rd);
        end
        for (int k = 0; k <= NA; k++) r_a[k] <= n_a[k];
        r_h1 <= n_h1;
        r_h2 <= n_h2;
        r_m1 <= n_m1;
        r_c  <= n_c;
        if (r_cv) begin
            r_mem[r_wp] <= res;
        end
    end

endmodule
